>>> hdl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// shared types and constants of the fixed block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int MAX_CHUNKS = 256;
  localparam int IDX_W      = 8;
  localparam int COUNT_W    = 9;
  localparam int ENTRY_W    = IDX_W + 1;

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_CHUNKS);

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK           = 2'd0,
    STAT_EMPTY        = 2'd1,
    STAT_ALREADY_FREE = 2'd2,
    STAT_RANGE        = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_state_t;

  // one request item
  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] chunk_index;
  } req_t;

  // one result item
  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] granted_index;
  } rsp_t;

  // one word of the pool memory: allocated mark and free-list link
  typedef struct packed {
    logic             mark;
    logic [IDX_W-1:0] link;
  } entry_t;

  // access to the pool memory
  typedef struct packed {
    logic             en;
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           wdata;
  } mem_req_t;

endpackage

>>> hdl/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// pool allocator for equal-size chunks with a lifo free list in block ram
// ----------------------------------------------------------------------------
//
//  channel   ports                   transfer when
//  --------  ----------------------  ---------------------------------
//  request   start, busy, req        rising edge with start high, busy low
//  result    done, rsp               every rising edge that ends a done cycle
//  config    cfg_we, cfg_data        rising edge with cfg_we high
//
//  each request takes two steps: a read of the pool entry from the single
//  port ram, then a decision and write-back; the next request is taken in
//  the cycle after that, so a new request is never taken while one is in work
//  the result shows on done/rsp in the cycle after the write-back cycle, while
//  the next request may already be transferred
//  reset (synchronous, rst high) leaves 256 chunks, all free; it needs no
//  sweep of the ram, as marks at or above the fresh count are taken as clear
//  the receiver cannot stall results, so nothing ever backs up
//
module fixed_block_pool_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  fbpa_pkg::req_t               req,
  output logic                         done,
  output fbpa_pkg::rsp_t               rsp,
  input  logic                         cfg_we,
  input  logic [fbpa_pkg::COUNT_W-1:0] cfg_data
);

  // chunk count register; values above the pool size act as the pool size
  logic [fbpa_pkg::COUNT_W-1:0] num_chunks;
  logic [fbpa_pkg::COUNT_W-1:0] eff_count;

  fbpa_pkg::mem_req_t mem_req;
  fbpa_pkg::entry_t   rd_entry;
  logic               res_valid;
  fbpa_pkg::rsp_t     res;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_chunks <= fbpa_pkg::MAX_COUNT;
    end else if (cfg_we) begin
      num_chunks <= cfg_data;
    end
  end

  assign eff_count = (num_chunks > fbpa_pkg::MAX_COUNT) ? fbpa_pkg::MAX_COUNT : num_chunks;

  // sequencer: free-list head, list length and fresh count live here
  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .rebuild   (cfg_we),
    .eff_count (eff_count),
    .rd_entry  (rd_entry),
    .busy      (busy),
    .mem_req   (mem_req),
    .res_valid (res_valid),
    .res       (res)
  );

  // pool memory: one word per chunk holding its allocated mark and link
  fbpa_ram #(
    .DEPTH (fbpa_pkg::MAX_CHUNKS),
    .WIDTH (fbpa_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .en    (mem_req.en),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (rd_entry)
  );

  // result register parts the sequencer from the receiver
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      rsp <= res;
    end
  end

endmodule

>>> hdl/fbpa_ram.sv
// ----------------------------------------------------------------------------
// fbpa_ram
// single-port synchronous ram, registered read data
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 9,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

>>> hdl/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// fbpa_ctrl
// request sequencer: reads the pool entry, decides, writes it back
// ----------------------------------------------------------------------------
module fbpa_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  fbpa_pkg::req_t               req,
  input  logic                         rebuild,
  input  logic [fbpa_pkg::COUNT_W-1:0] eff_count,
  input  fbpa_pkg::entry_t             rd_entry,
  output logic                         busy,
  output fbpa_pkg::mem_req_t           mem_req,
  output logic                         res_valid,
  output fbpa_pkg::rsp_t               res
);

  fbpa_pkg::fsm_state_t state, state_next;

  fbpa_pkg::kind_t                op_kind;
  logic [fbpa_pkg::IDX_W-1:0]     op_idx;
  logic [fbpa_pkg::IDX_W-1:0]     free_head, free_head_next;
  logic [fbpa_pkg::COUNT_W-1:0]   list_len, list_len_next;
  logic [fbpa_pkg::COUNT_W-1:0]   fresh_count, fresh_count_next;

  logic accept;
  logic idx_in_range;
  logic idx_allocated;

  assign accept = start && (state == fbpa_pkg::FSM_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fbpa_pkg::FSM_IDLE: begin
        if (accept) begin
          state_next = fbpa_pkg::FSM_EXEC;
        end
      end
      fbpa_pkg::FSM_EXEC: begin
        state_next = fbpa_pkg::FSM_IDLE;
      end
      default: begin
        state_next = fbpa_pkg::FSM_IDLE;
      end
    endcase
  end

  // entries at or above the fresh count were never handed out since rebuild
  assign idx_in_range  = {1'b0, op_idx} < eff_count;
  assign idx_allocated = ({1'b0, op_idx} < fresh_count) && rd_entry.mark;

  // outputs and free-list update
  always_comb begin
    busy             = 1'b0;
    res_valid        = 1'b0;
    res.status       = fbpa_pkg::STAT_OK;
    res.granted_index = '0;
    mem_req.en       = 1'b0;
    mem_req.we       = 1'b0;
    mem_req.addr     = free_head;
    mem_req.wdata    = rd_entry;
    free_head_next   = free_head;
    list_len_next    = list_len;
    fresh_count_next = fresh_count;
    case (state)
      fbpa_pkg::FSM_IDLE: begin
        mem_req.en   = start;
        mem_req.addr = (req.kind == fbpa_pkg::KIND_FREE) ? req.chunk_index : free_head;
      end
      fbpa_pkg::FSM_EXEC: begin
        busy      = 1'b1;
        res_valid = 1'b1;
        if (op_kind == fbpa_pkg::KIND_ALLOC) begin
          if (list_len != '0) begin
            // pop the most recently freed chunk
            res.granted_index  = free_head;
            mem_req.en         = 1'b1;
            mem_req.we         = 1'b1;
            mem_req.addr       = free_head;
            mem_req.wdata.mark = 1'b1;
            mem_req.wdata.link = rd_entry.link;
            free_head_next     = rd_entry.link;
            list_len_next      = list_len - 1'b1;
          end else if (fresh_count < eff_count) begin
            // hand out the next never-used chunk
            res.granted_index  = fresh_count[fbpa_pkg::IDX_W-1:0];
            mem_req.en         = 1'b1;
            mem_req.we         = 1'b1;
            mem_req.addr       = fresh_count[fbpa_pkg::IDX_W-1:0];
            mem_req.wdata.mark = 1'b1;
            mem_req.wdata.link = '0;
            fresh_count_next   = fresh_count + 1'b1;
          end else begin
            res.status = fbpa_pkg::STAT_EMPTY;
          end
        end else begin
          if (!idx_in_range) begin
            res.status = fbpa_pkg::STAT_RANGE;
          end else if (!idx_allocated) begin
            res.status = fbpa_pkg::STAT_ALREADY_FREE;
          end else begin
            // push the chunk on top of the free list
            mem_req.en         = 1'b1;
            mem_req.we         = 1'b1;
            mem_req.addr       = op_idx;
            mem_req.wdata.mark = 1'b0;
            mem_req.wdata.link = free_head;
            free_head_next     = op_idx;
            list_len_next      = list_len + 1'b1;
          end
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= fbpa_pkg::FSM_IDLE;
      free_head   <= '0;
      list_len    <= '0;
      fresh_count <= '0;
    end else begin
      state <= state_next;
      if (rebuild) begin
        free_head   <= '0;
        list_len    <= '0;
        fresh_count <= '0;
      end else begin
        free_head   <= free_head_next;
        list_len    <= list_len_next;
        fresh_count <= fresh_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind <= req.kind;
      op_idx  <= req.chunk_index;
    end
  end

endmodule

>>> hdl/fbpa_checker.sv
// ----------------------------------------------------------------------------
// fbpa_checker
// port-level timing checks of the pool allocator, bound to the top level
// ----------------------------------------------------------------------------
module fbpa_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input fbpa_pkg::rsp_t rsp
);

  // a transfer makes the block busy in the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("no busy cycle after request transfer");

  // busy lasts exactly one cycle
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // every request yields its result once the work cycle and the result register have passed
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("result missing after request transfer");

  // a result only follows a busy cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without preceding work cycle");

  // failed requests grant nothing
  a_no_grant_on_error: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != fbpa_pkg::STAT_OK) |-> (rsp.granted_index == '0))
    else $error("nonzero granted index on failed request");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
